### hw/rtl/dfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_pkg
// shared types and constants of the depth-first topological sorter
// ----------------------------------------------------------------------------
package dfs_pkg;

  localparam int unsigned NodeW   = 7;
  localparam int unsigned StatusW = 2;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_CYCLE = 2'd1,
    ST_BAD   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MARK_NEW  = 2'd0,
    MARK_PATH = 2'd1,
    MARK_DONE = 2'd2
  } mark_e;

  typedef struct packed {
    logic [NodeW-1:0] node;
    status_e          status;
    logic             last;
  } result_t;

endpackage : dfs_pkg
`default_nettype wire

### hw/rtl/dfs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module dfs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : dfs_ram
`default_nettype wire

### hw/rtl/dfs_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_out_buf
// output register that holds one result until the receiver takes it
// ----------------------------------------------------------------------------
module dfs_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire dfs_pkg::result_t data_i,
  output logic                  full_o,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output dfs_pkg::result_t      data_o
);
  import dfs_pkg::*;

  logic    valid_q;
  result_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  // a push is only issued when the slot is free or being drained
  assign full_o          = valid_q && !m_axis_tready_i;
  assign m_axis_tvalid_o = valid_q;
  assign data_o          = data_q;

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into occupied output slot");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !m_axis_tready_i && !push_i) |=> (valid_q && $stable(data_q)))
    else $error("stalled result changed");
  a_last_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && data_q.status != ST_OK) |-> (data_q.last && data_q.node == '0))
    else $error("error result malformed");

endmodule : dfs_out_buf
`default_nettype wire

### hw/rtl/dfs_topological_sort_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_topological_sort_top
// depth-first topological sort with cycle detection
// ----------------------------------------------------------------------------
// s_axis carries requests: tuser = action (0 load edge, 1 run), tdata holds
// from_node [6:0] and to_node [13:7]. an edge load reads head and tail on
// accept, writes the end mark, then target, tail and head or link.
// a run walks the graph out of on-chip rams: a root check reads mark and
// head and pushes a new root; an edge reads the stack top, target and link,
// then the target mark, pushing a new target; a finish pops. the finish
// order is read back, last finished node first, while the receiver takes
// them. after the run a clearing pass over nodes 0 to MaxNodes resets list
// heads and marks; it also runs once after reset, no request taken meanwhile.
// cfg_valid_i/cfg_ready_o write num_nodes while the block is idle.
// m_axis tdata = node [6:0], status [8:7]; tlast flags the final result.
// a stalled receiver holds the result in the output register and pauses
// the read back; nothing is lost.
// ----------------------------------------------------------------------------
module dfs_topological_sort_top #(
  parameter int unsigned MaxNodes = 64,
  parameter int unsigned MaxEdges = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [6:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // from_node[6:0], to_node[13:7]
  input  wire logic        s_axis_tuser,   // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // node[6:0], status[8:7]
  output logic             m_axis_tlast
);
  import dfs_pkg::*;

  localparam int unsigned EW  = $clog2(MaxEdges) + 1; // holds MaxEdges = empty
  localparam int unsigned EAW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int unsigned NAW = $clog2(MaxNodes + 1);
  localparam int unsigned SAW = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int unsigned CW  = $clog2(MaxNodes + 1);
  localparam logic [EW-1:0] NoEdge = EW'(MaxEdges);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LD_RD = 4'd2;
  localparam logic [3:0] S_LD_WR = 4'd3;
  localparam logic [3:0] S_ROOT  = 4'd4;
  localparam logic [3:0] S_RT_CK = 4'd5;
  localparam logic [3:0] S_TOP   = 4'd6;
  localparam logic [3:0] S_TOPD  = 4'd7;
  localparam logic [3:0] S_EDGE  = 4'd8;
  localparam logic [3:0] S_TGT   = 4'd9;
  localparam logic [3:0] S_PUSH  = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;
  localparam logic [3:0] S_ERR   = 4'd12;

  logic [3:0]      state_q, state_d;
  logic [6:0]      num_nodes_q;
  logic [NAW-1:0]  lim;
  logic [EW-1:0]   edge_cnt_q, edge_cnt_d;
  logic            bad_q, bad_d;
  logic [CW-1:0]   depth_q, depth_d, fin_q, fin_d;
  logic [NAW-1:0]  idx_q, idx_d;     // clear index / root / target
  logic [6:0]      a_q, a_d, b_q, b_d;
  logic [NodeW-1:0] v_q, v_d;
  logic [EW-1:0]   cur_q, cur_d;
  status_e         err_q, err_d;

  // ram ports
  logic            tg_we, lk_we, hd_we, tl_we, mk_we, sn_we, sc_we, fo_we;
  logic [EAW-1:0]  tg_wa, tg_ra, lk_wa, lk_ra;
  logic [6:0]      tg_wd, tg_rd;
  logic [EW-1:0]   lk_wd, lk_rd, hd_wd, hd_rd, tl_wd, tl_rd, sc_wd, sc_rd;
  logic [NAW-1:0]  hd_wa, hd_ra, tl_wa, tl_ra, mk_wa, mk_ra;
  logic [1:0]      mk_wd, mk_rd;
  logic [SAW-1:0]  sn_wa, sn_ra, sc_wa, sc_ra, fo_wa, fo_ra;
  logic [NodeW-1:0] sn_wd, sn_rd, fo_wd, fo_rd;

  logic            push, buf_full;
  result_t         res, res_o;

  dfs_ram #(.Width(7),  .Depth(MaxEdges)) u_tgt (.clk_i, .we_i(tg_we),
    .waddr_i(tg_wa), .wdata_i(tg_wd), .raddr_i(tg_ra), .rdata_o(tg_rd));
  dfs_ram #(.Width(EW), .Depth(MaxEdges)) u_lnk (.clk_i, .we_i(lk_we),
    .waddr_i(lk_wa), .wdata_i(lk_wd), .raddr_i(lk_ra), .rdata_o(lk_rd));
  dfs_ram #(.Width(EW), .Depth(MaxNodes+1)) u_hd (.clk_i, .we_i(hd_we),
    .waddr_i(hd_wa), .wdata_i(hd_wd), .raddr_i(hd_ra), .rdata_o(hd_rd));
  dfs_ram #(.Width(EW), .Depth(MaxNodes+1)) u_tl (.clk_i, .we_i(tl_we),
    .waddr_i(tl_wa), .wdata_i(tl_wd), .raddr_i(tl_ra), .rdata_o(tl_rd));
  dfs_ram #(.Width(2),  .Depth(MaxNodes+1)) u_mk (.clk_i, .we_i(mk_we),
    .waddr_i(mk_wa), .wdata_i(mk_wd), .raddr_i(mk_ra), .rdata_o(mk_rd));
  dfs_ram #(.Width(NodeW), .Depth(MaxNodes)) u_sn (.clk_i, .we_i(sn_we),
    .waddr_i(sn_wa), .wdata_i(sn_wd), .raddr_i(sn_ra), .rdata_o(sn_rd));
  dfs_ram #(.Width(EW), .Depth(MaxNodes)) u_sc (.clk_i, .we_i(sc_we),
    .waddr_i(sc_wa), .wdata_i(sc_wd), .raddr_i(sc_ra), .rdata_o(sc_rd));
  dfs_ram #(.Width(NodeW), .Depth(MaxNodes)) u_fo (.clk_i, .we_i(fo_we),
    .waddr_i(fo_wa), .wdata_i(fo_wd), .raddr_i(fo_ra), .rdata_o(fo_rd));

  dfs_out_buf u_out (.clk_i, .rst_ni, .push_i(push), .data_i(res),
    .full_o(buf_full), .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready), .data_o(res_o));

  assign m_axis_tdata = {7'd0, res_o.status, res_o.node};
  assign m_axis_tlast = res_o.last;

  always_comb begin
    if (num_nodes_q > 7'(MaxNodes)) lim = NAW'(MaxNodes);
    else if (num_nodes_q == 7'd0)   lim = NAW'(1);
    else                            lim = NAW'(num_nodes_q);
  end

  assign cfg_ready_o   = (state_q == S_IDLE);
  assign s_axis_tready = (state_q == S_IDLE) && !m_axis_tvalid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_nodes_q <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      num_nodes_q <= cfg_data_i;
    end
  end

  logic [SAW-1:0] top;
  logic [6:0]     t_tgt;
  assign top = SAW'(depth_q - CW'(1));

  always_comb begin
    state_d = state_q; edge_cnt_d = edge_cnt_q; bad_d = bad_q;
    depth_d = depth_q; fin_d = fin_q; idx_d = idx_q; a_d = a_q; b_d = b_q;
    v_d = v_q; cur_d = cur_q; err_d = err_q;
    tg_we = 1'b0; tg_wa = EAW'(edge_cnt_q); tg_wd = b_q; tg_ra = EAW'(cur_q);
    lk_we = 1'b0; lk_wa = EAW'(edge_cnt_q); lk_wd = NoEdge; lk_ra = EAW'(cur_q);
    hd_we = 1'b0; hd_wa = NAW'(a_q); hd_wd = edge_cnt_q; hd_ra = idx_q;
    tl_we = 1'b0; tl_wa = NAW'(a_q); tl_wd = edge_cnt_q; tl_ra = NAW'(a_q);
    mk_we = 1'b0; mk_wa = idx_q; mk_wd = MARK_PATH; mk_ra = idx_q;
    sn_we = 1'b0; sn_wa = SAW'(depth_q); sn_wd = NodeW'(idx_q); sn_ra = top;
    sc_we = 1'b0; sc_wa = SAW'(depth_q); sc_wd = hd_rd; sc_ra = top;
    fo_we = 1'b0; fo_wa = SAW'(fin_q); fo_wd = v_q;
    fo_ra = SAW'(fin_q - CW'(1));
    push = 1'b0;
    res.node = '0; res.status = err_q; res.last = 1'b1;
    t_tgt = tg_rd;
    unique case (state_q)
      S_CLR: begin
        hd_we = 1'b1; hd_wa = idx_q; hd_wd = NoEdge;
        mk_we = 1'b1; mk_wd = MARK_NEW;
        edge_cnt_d = '0; bad_d = 1'b0; depth_d = '0; fin_d = '0;
        if (idx_q == NAW'(MaxNodes)) state_d = S_IDLE;
        else idx_d = idx_q + NAW'(1);
      end
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          a_d = s_axis_tdata[6:0]; b_d = s_axis_tdata[13:7];
          if (s_axis_tuser) begin
            idx_d = NAW'(1);
            if (bad_q) begin
              err_d = ST_BAD; state_d = S_ERR;
            end else begin
              state_d = S_ROOT;
            end
          end else if (s_axis_tdata[6:0] == 7'd0 || s_axis_tdata[13:7] == 7'd0 ||
                       s_axis_tdata[6:0] > 7'(lim) || s_axis_tdata[13:7] > 7'(lim) ||
                       edge_cnt_q >= NoEdge) begin
            bad_d = 1'b1;
          end else begin
            idx_d = NAW'(s_axis_tdata[6:0]);
            hd_ra = NAW'(s_axis_tdata[6:0]);
            tl_ra = NAW'(s_axis_tdata[6:0]);
            state_d = S_LD_RD;
          end
        end
      end
      // end mark of the new edge goes in while head and tail are read
      S_LD_RD: begin
        lk_we = 1'b1;
        state_d = S_LD_WR;
      end
      S_LD_WR: begin
        tg_we = 1'b1; tl_we = 1'b1;
        if (hd_rd >= NoEdge) begin
          hd_we = 1'b1;
        end else begin
          lk_we = 1'b1; lk_wa = EAW'(tl_rd); lk_wd = edge_cnt_q;
        end
        edge_cnt_d = edge_cnt_q + EW'(1);
        state_d = S_IDLE;
      end
      // read mark and head of the candidate root
      S_ROOT: begin
        if (idx_q > lim) begin
          state_d = S_EMIT; // walk complete, fin_q nodes to emit
        end else begin
          state_d = S_RT_CK;
        end
      end
      S_RT_CK: begin
        if (mk_rd == MARK_NEW) state_d = S_PUSH;
        else begin
          idx_d = idx_q + NAW'(1); state_d = S_ROOT;
        end
      end
      // push node idx_q with cursor = head (head and mark read last cycle)
      S_PUSH: begin
        if (depth_q < CW'(MaxNodes)) begin
          sn_we = 1'b1; sc_we = 1'b1; mk_we = 1'b1; mk_wd = MARK_PATH;
          depth_d = depth_q + CW'(1);
        end
        state_d = S_TOP;
      end
      S_TOP: begin
        if (depth_q == '0) begin
          idx_d = idx_q + NAW'(1); // back to root scan; idx holds last target
          state_d = S_ROOT;
        end else begin
          state_d = S_TOPD;
        end
      end
      S_TOPD: begin
        v_d = sn_rd; cur_d = sc_rd;
        if (sc_rd >= NoEdge) begin
          mk_we = 1'b1; mk_wa = NAW'(sn_rd); mk_wd = MARK_DONE;
          if (fin_q < CW'(MaxNodes)) begin
            fo_we = 1'b1; fo_wd = sn_rd; fin_d = fin_q + CW'(1);
          end
          depth_d = depth_q - CW'(1);
          state_d = S_TOP;
        end else begin
          tg_ra = EAW'(sc_rd); lk_ra = EAW'(sc_rd);
          state_d = S_EDGE;
        end
      end
      S_EDGE: begin
        sc_we = 1'b1; sc_wa = top; sc_wd = lk_rd;
        idx_d = NAW'(t_tgt);
        if (t_tgt == 7'd0 || t_tgt > 7'(lim)) begin
          err_d = ST_BAD; state_d = S_ERR;
        end else begin
          mk_ra = NAW'(t_tgt); hd_ra = NAW'(t_tgt);
          state_d = S_TGT;
        end
      end
      S_TGT: begin
        if (mk_rd == MARK_PATH) begin
          err_d = ST_CYCLE; state_d = S_ERR;
        end else if (mk_rd == MARK_NEW) state_d = S_PUSH;
        else state_d = S_TOP;
      end
      // fo read addressed by fin_q-1, data shows next cycle; idx_q flags it
      S_EMIT: begin
        if (fin_q == '0) begin
          idx_d = '0; state_d = S_CLR;
        end else if (idx_q == NAW'(0)) begin
          if (!buf_full) begin
            push = 1'b1; res.node = fo_rd; res.status = ST_OK;
            res.last = (fin_q == CW'(1));
            fin_d = fin_q - CW'(1);
            idx_d = NAW'(1);
          end
        end else begin
          idx_d = NAW'(0); // read latency slot
        end
      end
      S_ERR: begin
        if (!buf_full) begin
          push = 1'b1; idx_d = '0; state_d = S_CLR;
        end
      end
      default: state_d = S_CLR;
    endcase
    // S_ROOT exit into emit primes the read latency slot
    if (state_q == S_ROOT && state_d == S_EMIT) idx_d = NAW'(1);
    // S_TOP into root scan must resume after the last root, not the target
    if (state_q == S_TOP && depth_q == '0) idx_d = NAW'(a_q) + NAW'(1);
    if (state_q == S_RT_CK && mk_rd == MARK_NEW) a_d = 7'(idx_q);
    if (state_q == S_IDLE && s_axis_tvalid && s_axis_tready && s_axis_tuser) a_d = 7'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; edge_cnt_q <= '0; bad_q <= 1'b0; depth_q <= '0;
      fin_q <= '0; idx_q <= '0; err_q <= ST_OK;
    end else begin
      state_q <= state_d; edge_cnt_q <= edge_cnt_d; bad_q <= bad_d;
      depth_q <= depth_d; fin_q <= fin_d; idx_q <= idx_d; err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; v_q <= v_d; cur_q <= cur_d;
  end

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= CW'(MaxNodes)) else $error("stack depth overflow");
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == S_CLR && state_q == S_IDLE) |-> (edge_cnt_q == '0 && !bad_q))
    else $error("state not cleared after pass");
  a_no_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready) else $error("request taken while busy");

endmodule : dfs_topological_sort_top
`default_nettype wire

### test/dfs_topological_sort_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dfs_topological_sort_top_test
// loads random and directed graphs, runs the sort and checks every result
// against a depth-first walk computed here; node count changed between phases
// ----------------------------------------------------------------------------
module dfs_topological_sort_top_test;
  import dfs_pkg::*;

  localparam int unsigned MaxN   = 64;
  localparam int unsigned MaxE   = 256;
  localparam int unsigned NoEdge = MaxE;
  localparam int unsigned WdogLimit = 20000;

  typedef enum logic {ACT_EDGE = 1'b0, ACT_RUN = 1'b1} action_e;

  typedef struct packed {
    action_e    action;
    logic [6:0] src;
    logic [6:0] dst;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [6:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic m_axis_tlast;

  always #1 clk_i = ~clk_i;

  dfs_topological_sort_top u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  // sorter model state
  int unsigned num_nodes;
  int unsigned edge_dst[MaxE];
  int unsigned edge_next[MaxE];
  int unsigned head[MaxN+1];
  int unsigned tail[MaxN+1];
  mark_e mark[MaxN+1];
  int unsigned edges_held;
  bit edge_dropped;

  request_t pending_q[$];
  result_t order_q[$];
  int idle_in_pct = 9;
  int idle_out_pct = 55;
  int errors = 0;
  int wdog = 0;

  function automatic void clear_graph();
    for (int i = 0; i <= MaxN; i++) begin
      head[i] = NoEdge;
      mark[i] = MARK_NEW;
    end
    edges_held = 0;
    edge_dropped = 1'b0;
  endfunction

  function automatic int unsigned eff_nodes();
    int unsigned n;
    n = num_nodes;
    if (n > MaxN) n = MaxN;
    if (n == 0) n = 1;
    return n;
  endfunction

  // depth-first walk; fills finished list, returns status
  function automatic status_e sort_walk(int unsigned n, ref int unsigned done[$]);
    int unsigned stk_v[$];
    int unsigned stk_e[$];
    int unsigned v, e, t;
    for (int unsigned r = 1; r <= n; r++) begin
      if (mark[r] != MARK_NEW) continue;
      stk_v = {stk_v, r}; stk_e = {stk_e, head[r]}; mark[r] = MARK_PATH;
      while (stk_v.size() > 0) begin
        v = stk_v[$];
        e = stk_e[$];
        if (e >= NoEdge) begin
          mark[v] = MARK_DONE;
          done = {done, v};
          void'(stk_v.pop_back()); void'(stk_e.pop_back());
        end else begin
          t = edge_dst[e];
          stk_e[stk_e.size()-1] = edge_next[e];
          if (t == 0 || t > n) return ST_BAD;
          if (mark[t] == MARK_PATH) return ST_CYCLE;
          if (mark[t] == MARK_NEW) begin
            stk_v = {stk_v, t}; stk_e = {stk_e, head[t]}; mark[t] = MARK_PATH;
          end
        end
      end
    end
    return ST_OK;
  endfunction

  function automatic void predict_sort(request_t rq);
    int unsigned n, a, b;
    int unsigned done[$];
    status_e st;
    result_t r;
    n = eff_nodes();
    a = rq.src;
    b = rq.dst;
    if (rq.action == ACT_EDGE) begin
      if (a == 0 || a > n || b == 0 || b > n || edges_held >= MaxE) begin
        edge_dropped = 1'b1;
        return;
      end
      edge_dst[edges_held] = b;
      edge_next[edges_held] = NoEdge;
      if (head[a] >= NoEdge) head[a] = edges_held;
      else edge_next[tail[a]] = edges_held;
      tail[a] = edges_held;
      edges_held++;
      return;
    end
    st = edge_dropped ? ST_BAD : sort_walk(n, done);
    if (st != ST_OK) begin
      r.node = '0; r.status = st; r.last = 1'b1;
      order_q = {order_q, r};
    end else begin
      for (int k = done.size() - 1; k >= 0; k--) begin
        r.node = done[k][6:0]; r.status = ST_OK; r.last = (k == 0);
        order_q = {order_q, r};
      end
    end
    clear_graph();
  endfunction

  // request driver and receiver ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
          request_t rq;
          rq = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= rq.action;
          s_axis_tdata <= {2'b00, rq.dst, rq.src};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= idle_out_pct);
    end
  end

  // request prediction, result checking and stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      bit moved;
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        request_t rq;
        rq.action = action_e'(s_axis_tuser);
        rq.src = s_axis_tdata[6:0];
        rq.dst = s_axis_tdata[13:7];
        predict_sort(rq);
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (order_q.size() == 0) begin
          $error("unexpected result node %0d", m_axis_tdata[6:0]);
          errors++;
        end else begin
          result_t x;
          x = order_q.pop_front();
          if (m_axis_tdata[6:0] !== x.node) begin
            $error("node: expected %0d, got %0d", x.node, m_axis_tdata[6:0]); errors++;
          end
          if (m_axis_tdata[8:7] !== x.status) begin
            $error("status: expected %0d, got %0d", x.status, m_axis_tdata[8:7]); errors++;
          end
          if (m_axis_tlast !== x.last) begin
            $error("last: expected %0d, got %0d", x.last, m_axis_tlast); errors++;
          end
        end
      end
      wdog <= moved ? 0 : wdog + 1;
      if (wdog >= WdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic push_req(action_e act, int unsigned a, int unsigned b);
    request_t rq;
    rq.action = act; rq.src = a[6:0]; rq.dst = b[6:0];
    pending_q = {pending_q, rq};
  endtask

  // random graph: mostly forward edges (acyclic), sometimes a back edge or noise
  task automatic random_graph(int unsigned n, int unsigned edges);
    int unsigned a, b, p;
    for (int i = 0; i < edges; i++) begin
      p = $urandom_range(99);
      a = $urandom_range(n, 1);
      b = $urandom_range(n, 1);
      if (p < 3) begin
        a = $urandom_range(127);
        b = $urandom_range(127);
      end else if (p < 90 && a == b) begin
        if (a < n) b = a + 1; else a = 1;
      end else if (p < 90 && a > b) begin
        p = a; a = b; b = p;
      end
      push_req(ACT_EDGE, a, b);
    end
    push_req(ACT_RUN, $urandom_range(127), $urandom_range(127));
  endtask

  task automatic drain_and_wait();
    while (pending_q.size() > 0 || s_axis_tvalid || order_q.size() > 0) @(posedge clk_i);
    // edge loads and the clearing pass after a run
    repeat (MaxN + 20) @(posedge clk_i);
  endtask

  task automatic write_nodes(int unsigned v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v[6:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    num_nodes = v;
  endtask

  initial begin
    int unsigned n;
    num_nodes = 64;
    clear_graph();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (MaxN + 10) @(posedge clk_i);

    // directed: chain, cycle, self loop, bad endpoints, empty run
    push_req(ACT_EDGE, 1, 2); push_req(ACT_EDGE, 2, 64); push_req(ACT_EDGE, 64, 3);
    push_req(ACT_RUN, 0, 0);
    push_req(ACT_EDGE, 5, 6); push_req(ACT_EDGE, 6, 5); push_req(ACT_RUN, 127, 127);
    push_req(ACT_EDGE, 9, 9); push_req(ACT_RUN, 0, 0);
    push_req(ACT_EDGE, 0, 4); push_req(ACT_RUN, 0, 0);
    push_req(ACT_EDGE, 4, 65); push_req(ACT_EDGE, 127, 127); push_req(ACT_RUN, 0, 0);
    push_req(ACT_RUN, 0, 0);
    drain_and_wait();

    // node count lowered after loading, then extremes of the setting
    write_nodes(8);
    push_req(ACT_EDGE, 2, 8); push_req(ACT_EDGE, 8, 1);
    drain_and_wait();
    write_nodes(4);
    push_req(ACT_EDGE, 1, 3); push_req(ACT_RUN, 0, 0);
    drain_and_wait();
    write_nodes(0);
    push_req(ACT_EDGE, 1, 1); push_req(ACT_RUN, 0, 0); push_req(ACT_RUN, 0, 0);
    drain_and_wait();
    write_nodes(127);
    push_req(ACT_EDGE, 64, 1); push_req(ACT_RUN, 0, 0);
    drain_and_wait();

    for (int ph = 0; ph < 3; ph++) begin
      idle_in_pct = (ph == 0) ? 9 : (ph == 1) ? 55 : 0;
      idle_out_pct = (ph == 0) ? 55 : (ph == 1) ? 9 : 0;
      for (int s = 0; s < 3; s++) begin
        n = (s == 0) ? 1 : (s == 1) ? 64 : $urandom_range(16, 2);
        write_nodes(n);
        random_graph(n, (n == 1) ? 3 :
                        (n == 64) ? $urandom_range(48, 16) : $urandom_range(2 * n, 1));
        random_graph(n, $urandom_range(8));
        drain_and_wait();
      end
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
